@@ hw/rtl/gabk_pkg.sv @@
// shared types, constants and fixed-point helpers of the gabor kernel generator
`default_nettype none

package gabk_pkg;

  // scale and output format
  localparam int MAX_SCALE  = 4;
  localparam int FRAC_BITS  = 15;
  localparam int SHIFT_BASE = 60 - FRAC_BITS;

  // pipeline geometry
  localparam int GAUSS_CELLS = 10;
  localparam int SIN_CELLS   = 6;
  localparam int COS_CELLS   = 7;
  localparam int PIPE_DEPTH  = 20;

  // configuration register indexes (paddr bit 2)
  localparam logic REG_ORIENTATION = 1'b0;
  localparam logic REG_SCALE       = 1'b1;

  // q30 constants
  localparam logic [31:0] Q_ONE      = 32'h4000_0000;
  localparam logic [31:0] Q_HALF     = 32'h2000_0000;
  localparam logic [31:0] PI8_Q30    = 32'd421657428;
  localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
  localparam logic signed [33:0] EXPNPI_Q30 = 34'sd46400589;

  // reciprocals for exact floor division of 32-bit values: ceil(2^40 / k)
  localparam logic [63:0] RECIP_ONE = 64'd1 << 40;
  localparam logic [39:0] SIN_RECIP [SIN_CELLS] = '{
    40'((RECIP_ONE + 64'd155) / 64'd156), 40'((RECIP_ONE + 64'd109) / 64'd110),
    40'((RECIP_ONE + 64'd71) / 64'd72),   40'((RECIP_ONE + 64'd41) / 64'd42),
    40'((RECIP_ONE + 64'd19) / 64'd20),   40'((RECIP_ONE + 64'd5) / 64'd6)};
  localparam logic [39:0] COS_RECIP [COS_CELLS] = '{
    40'((RECIP_ONE + 64'd181) / 64'd182), 40'((RECIP_ONE + 64'd131) / 64'd132),
    40'((RECIP_ONE + 64'd89) / 64'd90),   40'((RECIP_ONE + 64'd55) / 64'd56),
    40'((RECIP_ONE + 64'd29) / 64'd30),   40'((RECIP_ONE + 64'd11) / 64'd12),
    40'((RECIP_ONE + 64'd1) / 64'd2)};

  // transaction payloads
  typedef struct packed {
    logic [5:0] row;
    logic [5:0] column;
  } gabk_item_t;

  typedef struct packed {
    logic signed [15:0] real_coef;
    logic signed [15:0] imag_coef;
    logic [5:0]         mask_size;
    logic               outside_mask;
  } gabk_result_t;

  // rounded q30 product
  function automatic logic [33:0] qmul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 34'((p + 64'(Q_HALF)) >> 30);
  endfunction

  // mask width per scale
  function automatic logic [5:0] width_of(input logic [2:0] nu);
    case (nu)
      3'd0:    return 6'd11;
      3'd1:    return 6'd15;
      3'd2:    return 6'd21;
      3'd3:    return 6'd29;
      default: return 6'd39;
    endcase
  endfunction

  // mask centre per scale
  function automatic logic [4:0] center_of(input logic [2:0] nu);
    case (nu)
      3'd0:    return 5'd5;
      3'd1:    return 5'd7;
      3'd2:    return 5'd10;
      3'd3:    return 5'd14;
      default: return 5'd19;
    endcase
  endfunction

  // exp(-(pi/16)/2^nu) in q30
  function automatic logic [31:0] gauss_of(input logic [2:0] nu);
    case (nu)
      3'd0:    return 32'd882320455;
      3'd1:    return 32'd973336724;
      3'd2:    return 32'd1022307365;
      3'd3:    return 32'd1047709013;
      default: return 32'd1060645552;
    endcase
  endfunction

  // 2^(-nu/2) in q28
  function automatic logic [28:0] root_of(input logic [2:0] nu);
    case (nu)
      3'd0:    return 29'd268435456;
      3'd1:    return 29'd189812531;
      3'd2:    return 29'd134217728;
      3'd3:    return 29'd94906266;
      default: return 29'd67108864;
    endcase
  endfunction

  // cos(pi*mu/8) in q30
  function automatic logic signed [31:0] cos_of(input logic [2:0] mu);
    case (mu)
      3'd0:    return 32'sd1073741824;
      3'd1:    return 32'sd992008095;
      3'd2:    return 32'sd759250125;
      3'd3:    return 32'sd410903203;
      3'd4:    return 32'sd0;
      3'd5:    return -32'sd410903203;
      3'd6:    return -32'sd759250125;
      default: return -32'sd992008095;
    endcase
  endfunction

  // sin(pi*mu/8) in q30
  function automatic logic signed [31:0] sin_of(input logic [2:0] mu);
    case (mu)
      3'd0:    return 32'sd0;
      3'd1:    return 32'sd410903203;
      3'd2:    return 32'sd759250125;
      3'd3:    return 32'sd992008095;
      3'd4:    return 32'sd1073741824;
      3'd5:    return 32'sd992008095;
      3'd6:    return 32'sd759250125;
      default: return 32'sd410903203;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gabk_gauss_cell.sv @@
// one square-and-multiply cell of the gaussian power chain
`default_nettype none

module gabk_gauss_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [9:0]  r2_in,
  input  logic [31:0] acc_in,
  input  logic [31:0] base_in,
  output logic [9:0]  r2_out,
  output logic [31:0] acc_out,
  output logic [31:0] base_out
);
  import gabk_pkg::*;

  logic [33:0] acc_prod;
  logic [33:0] base_prod;

  // multiply in the base for the lowest exponent bit, square the base
  assign acc_prod  = qmul32(acc_in, base_in);
  assign base_prod = qmul32(base_in, base_in);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_out   <= r2_in >> 1;
      acc_out  <= r2_in[0] ? acc_prod[31:0] : acc_in;
      base_out <= base_prod[31:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gabk_horner_cell.sv @@
// one horner step t = 1 - z*t/k of the sine or cosine series, two stages
`default_nettype none

module gabk_horner_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] z_in,
  input  logic [31:0] t_in,
  input  logic [39:0] recip,
  output logic [31:0] z_out,
  output logic [31:0] t_out
);
  import gabk_pkg::*;

  logic [33:0] zt_prod;
  logic [31:0] z_mid;
  logic [31:0] zt_mid;
  logic [71:0] quot_prod;
  logic [31:0] quot;

  assign zt_prod = qmul32(z_in, t_in);

  // floor division by the series constant through its reciprocal
  assign quot_prod = 72'(zt_mid) * 72'(recip);
  assign quot      = quot_prod[71:40];

  always_ff @(posedge clk) begin
    if (en) begin
      z_mid  <= z_in;
      zt_mid <= zt_prod[31:0];
      z_out  <= z_mid;
      t_out  <= (quot > Q_ONE) ? 32'd0 : (Q_ONE - quot);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gabor_kernel_generator_top.sv @@
// top level of the gabor kernel generator: config registers, pipeline and output buffer
`default_nettype none

// Generates one coefficient pair of a dc-compensated complex gabor kernel per
// transaction. Orientation (mu, angle pi*mu/8) and scale (nu, saturated to 4) are set
// through the apb port at byte addresses 0 and 4; write them only while the block is
// idle. Each input transaction carries a row and column; the result carries the real
// and imaginary coefficient in q1.15 rounded half away from zero, the odd mask width
// for the scale and a flag for positions outside the mask, where both coefficients
// are zero. One item is taken every cycle while the skid entry is empty; the depth of
// the pipeline is set by the seven two-stage cosine series cells behind the phase
// stages. A two-entry output buffer, the result register and a skid entry, catches the
// result still in flight when result_ready drops.
module gabor_kernel_generator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  gabk_pkg::gabk_item_t  item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output gabk_pkg::gabk_result_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import gabk_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [2:0] orientation;
  logic [2:0] scale;
  logic [2:0] nu;
  logic       en;

  logic [PIPE_DEPTH-1:0] vld;

  // stage 1
  logic signed [6:0]  x_c, y_c;
  logic signed [13:0] xx_c, yy_c;
  logic [14:0]        r2_c;
  logic signed [39:0] sum_c;
  logic [5:0]         w_c;
  logic [9:0]         r2_1;
  logic signed [39:0] sum_1;
  logic               out_1;

  // gaussian chain
  logic [9:0]  g_r2   [GAUSS_CELLS+1];
  logic [31:0] g_acc  [GAUSS_CELLS+1];
  logic [31:0] g_base [GAUSS_CELLS+1];
  logic [33:0] g_prod;
  logic [31:0] g_12;
  logic [31:0] g_line [6];

  // phase stages
  logic [59:0] ph_c;
  logic [1:0]  q_2, q_3, q_4;
  logic [29:0] u_2;
  logic [33:0] a_prod, z_prod, sn_prod;
  logic [31:0] a_3, a_4, z_4;
  logic [31:0] a_line [12];
  logic [1:0]  q_line [14];
  logic        out_line [17];

  // series chains
  logic [31:0] sin_z [SIN_CELLS+1];
  logic [31:0] sin_t [SIN_CELLS+1];
  logic [31:0] cos_z [COS_CELLS+1];
  logic [31:0] cos_t [COS_CELLS+1];
  logic [31:0] sn_17, sn_18;

  // quadrant, dc removal and scaling
  logic signed [33:0] sn_s, cs_s, sv_c, cv_c, fre_c;
  logic [32:0]        mag_re, mag_im;
  logic [63:0]        prod_re, prod_im;
  logic               neg_re, neg_im, out_19;
  logic [63:0]        rnd_re, rnd_im;
  logic [63:0]        r_re, r_im;
  gabk_result_t       res_c;
  gabk_result_t       p20;
  gabk_result_t       skid;
  logic               skid_full;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= 3'd0;
      scale       <= 3'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ORIENTATION: orientation <= pwdata[2:0];
        REG_SCALE:       scale       <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ORIENTATION: prdata = {29'd0, orientation};
      REG_SCALE:       prdata = {29'd0, scale};
      default:         prdata = 32'd0;
    endcase
  end

  assign nu = (scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : scale;

  // flow control
  assign en         = ~skid_full;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], item_valid};
    end
  end

  // position, radius and projected phase sum
  always_comb begin
    w_c   = width_of(nu);
    x_c   = $signed({1'b0, item.row}) - $signed({2'b0, center_of(nu)});
    y_c   = $signed({1'b0, item.column}) - $signed({2'b0, center_of(nu)});
    xx_c  = x_c * x_c;
    yy_c  = y_c * y_c;
    r2_c  = 15'(xx_c) + 15'(yy_c);
    sum_c = 40'(x_c) * 40'(cos_of(orientation)) + 40'(y_c) * 40'(sin_of(orientation));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_1  <= r2_c[9:0];
      sum_1 <= sum_c;
      out_1 <= (item.row >= w_c) || (item.column >= w_c);
    end
  end

  // gaussian: one exponent bit per cell
  assign g_r2[0]   = r2_1;
  assign g_acc[0]  = Q_ONE;
  assign g_base[0] = gauss_of(nu);

  for (genvar i = 0; i < GAUSS_CELLS; i++) begin : g_gauss
    gabk_gauss_cell u_cell (
      .clk      (clk),
      .en       (en),
      .r2_in    (g_r2[i]),
      .acc_in   (g_acc[i]),
      .base_in  (g_base[i]),
      .r2_out   (g_r2[i+1]),
      .acc_out  (g_acc[i+1]),
      .base_out (g_base[i+1])
    );
  end

  assign g_prod = qmul32(PI8_Q30, g_acc[GAUSS_CELLS]);

  // phase in turns, quadrant and angle
  assign ph_c   = 60'(sum_1) * {31'd0, root_of(nu)};
  assign a_prod = qmul32({2'b0, u_2}, HALFPI_Q30);
  assign z_prod = qmul32(a_3, a_3);

  always_ff @(posedge clk) begin
    if (en) begin
      q_2 <= ph_c[59:58];
      u_2 <= ph_c[57:28];
      q_3 <= q_2;
      a_3 <= a_prod[31:0];
      q_4 <= q_3;
      a_4 <= a_3;
      z_4 <= z_prod[31:0];
    end
  end

  // sine and cosine series chains
  assign sin_z[0] = z_4;
  assign sin_t[0] = Q_ONE;
  assign cos_z[0] = z_4;
  assign cos_t[0] = Q_ONE;

  for (genvar i = 0; i < SIN_CELLS; i++) begin : g_sin
    gabk_horner_cell u_cell (
      .clk   (clk),
      .en    (en),
      .z_in  (sin_z[i]),
      .t_in  (sin_t[i]),
      .recip (SIN_RECIP[i]),
      .z_out (sin_z[i+1]),
      .t_out (sin_t[i+1])
    );
  end

  for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos
    gabk_horner_cell u_cell (
      .clk   (clk),
      .en    (en),
      .z_in  (cos_z[i]),
      .t_in  (cos_t[i]),
      .recip (COS_RECIP[i]),
      .z_out (cos_z[i+1]),
      .t_out (cos_t[i+1])
    );
  end

  assign sn_prod = qmul32(a_line[11], sin_t[SIN_CELLS]);

  // alignment lines up to stage 18
  always_ff @(posedge clk) begin
    if (en) begin
      g_12      <= g_prod[31:0];
      g_line[0] <= g_12;
      for (int i = 1; i < 6; i++) g_line[i] <= g_line[i-1];
      a_line[0] <= a_4;
      for (int i = 1; i < 12; i++) a_line[i] <= a_line[i-1];
      q_line[0] <= q_4;
      for (int i = 1; i < 14; i++) q_line[i] <= q_line[i-1];
      out_line[0] <= out_1;
      for (int i = 1; i < 17; i++) out_line[i] <= out_line[i-1];
      sn_17 <= sn_prod[31:0];
      sn_18 <= sn_17;
    end
  end

  // quadrant unfold and dc-compensated real factor
  always_comb begin
    sn_s = $signed({2'b0, sn_18});
    cs_s = $signed({2'b0, cos_t[COS_CELLS]});
    case (q_line[13])
      QUAD_0: begin
        sv_c = sn_s;
        cv_c = cs_s;
      end
      QUAD_1: begin
        sv_c = cs_s;
        cv_c = -sn_s;
      end
      QUAD_2: begin
        sv_c = -sn_s;
        cv_c = -cs_s;
      end
      default: begin
        sv_c = -cs_s;
        cv_c = sn_s;
      end
    endcase
    fre_c  = cv_c - EXPNPI_Q30;
    mag_re = fre_c[33] ? 33'(-fre_c) : 33'(fre_c);
    mag_im = sv_c[33] ? 33'(-sv_c) : 33'(sv_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re <= 64'(g_line[5]) * 64'(mag_re);
      prod_im <= 64'(g_line[5]) * 64'(mag_im);
      neg_re  <= fre_c[33];
      neg_im  <= sv_c[33];
      out_19  <= out_line[16];
    end
  end

  // round, apply sign and saturate
  function automatic logic [15:0] sat_coef(input logic [63:0] r, input logic neg);
    if (neg) begin
      return (r > 64'd32768) ? 16'h8000 : 16'(~r[15:0] + 16'd1);
    end
    return (r > 64'd32767) ? 16'h7FFF : r[15:0];
  endfunction

  always_comb begin
    rnd_re = prod_re + (64'd1 << (SHIFT_BASE - 1 + int'(nu)));
    rnd_im = prod_im + (64'd1 << (SHIFT_BASE - 1 + int'(nu)));
    r_re   = rnd_re >> (SHIFT_BASE + int'(nu));
    r_im   = rnd_im >> (SHIFT_BASE + int'(nu));
    res_c.real_coef    = out_19 ? 16'sd0 : $signed(sat_coef(r_re, neg_re));
    res_c.imag_coef    = out_19 ? 16'sd0 : $signed(sat_coef(r_im, neg_im));
    res_c.mask_size    = width_of(nu);
    res_c.outside_mask = out_19;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p20 <= res_c;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (en && vld[PIPE_DEPTH-1]) begin
        skid      <= p20;
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      result       <= skid;
      result_valid <= 1'b1;
      skid_full    <= 1'b0;
    end else begin
      result_valid <= vld[PIPE_DEPTH-1];
      if (vld[PIPE_DEPTH-1]) begin
        result <= p20;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gabk_checker.sv @@
// port-level checks of the gabor kernel generator and their binding
`default_nettype none

module gabk_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_ready,
  input gabk_pkg::gabk_result_t result,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [2:0]             paddr,
  input logic [31:0]            pwdata,
  input logic [31:0]            prdata
);
  import gabk_pkg::*;

  // outside the mask both coefficients are zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.outside_mask |-> result.real_coef == 16'sd0 &&
      result.imag_coef == 16'sd0)
    else $error("nonzero coefficient outside mask");

  // mask width is one of the five scale widths
  a_mask_width: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.mask_size == 6'd11 || result.mask_size == 6'd15 ||
      result.mask_size == 6'd21 || result.mask_size == 6'd29 || result.mask_size == 6'd39)
    else $error("bad mask width");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a write to the scale register reads back masked to three bits
  a_scale_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] ##1 paddr[2] && !(psel && penable && pwrite)
      |-> prdata == {29'd0, $past(pwdata[2:0])})
    else $error("scale readback mismatch");

endmodule

bind gabor_kernel_generator_top gabk_checker u_gabk_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the gabor kernel generator: queued driver, checking monitor, apb setup
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gabk_pkg::*;

  localparam int PHASES = 10;
  localparam int RANDOM_PER_PHASE = 138;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] ADDR_ORIENTATION = {REG_ORIENTATION, 2'b00};
  localparam logic [2:0] ADDR_SCALE       = {REG_SCALE, 2'b00};

  // kernel tables
  localparam int WIDTHS [5] = '{11, 15, 21, 29, 39};
  localparam bit [63:0] GAUSS_BASE [5] = '{
    64'd882320455, 64'd973336724, 64'd1022307365, 64'd1047709013, 64'd1060645552};
  localparam bit [63:0] ROOT_SCALE [5] = '{
    64'd268435456, 64'd189812531, 64'd134217728, 64'd94906266, 64'd67108864};
  localparam longint COS_DIR [8] = '{1073741824, 992008095, 759250125, 410903203,
    0, -410903203, -759250125, -992008095};
  localparam longint SIN_DIR [8] = '{0, 410903203, 759250125, 992008095,
    1073741824, 992008095, 759250125, 410903203};
  localparam int SIN_TERMS [6] = '{156, 110, 72, 42, 20, 6};
  localparam int COS_TERMS [7] = '{182, 132, 90, 56, 30, 12, 2};
  localparam bit [63:0] ONE_Q30 = 64'd1 << 30;
  localparam bit [63:0] PI_EIGHTH = 64'd421657428;
  localparam bit [63:0] HALF_PI = 64'd1686629713;
  localparam longint DC_OFFSET = 46400589;

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  gabk_item_t item;
  gabk_result_t result;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  gabor_kernel_generator_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gabk_item_t pending_items [$];
  gabk_result_t expected_coefs [$];
  logic [2:0] shadow_mu, shadow_nu;
  logic calm;
  int errors, results_seen, items_sent, cycles;
  bit held;
  int hold_left;

  // rounded q30 product, wrapping like 64-bit hardware
  function automatic bit [63:0] qprod(input bit [63:0] a, input bit [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // truncated taylor series for sine or cosine core
  function automatic bit [63:0] taylor_core(input bit [63:0] z, input bit sine);
    bit [63:0] t, d;
    int n, k;
    t = ONE_Q30;
    n = sine ? 6 : 7;
    for (int i = 0; i < n; i++) begin
      k = sine ? SIN_TERMS[i] : COS_TERMS[i];
      d = qprod(z, t) / k;
      t = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    end
    return t;
  endfunction

  // scale to q1.15, round half away from zero, saturate
  function automatic logic [15:0] to_q15(input bit [63:0] g, input longint f, input int nu);
    bit neg;
    bit [63:0] mag, r;
    int s;
    neg = f < 0;
    mag = neg ? -f : f;
    s = 60 - FRAC_BITS + nu;
    r = (g * mag + (64'd1 << (s - 1))) >> s;
    if (neg) begin
      if (r > 32768) r = 32768;
      return 16'(-r);
    end
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

  // expected coefficient pair for one kernel position
  function automatic gabk_result_t kernel_coef(input logic [2:0] mu, input logic [2:0] nu_reg,
                                               input gabk_item_t it);
    gabk_result_t res;
    int nu, w, x, y;
    bit [31:0] r2;
    bit [63:0] acc, base, g, ph, u, a, z, sn, cs;
    longint sum, sv, cv;
    bit [1:0] quad;
    nu = (nu_reg > MAX_SCALE) ? MAX_SCALE : nu_reg;
    w = WIDTHS[nu];
    res = '0;
    res.mask_size = 6'(w);
    if (it.row >= w || it.column >= w) begin
      res.outside_mask = 1'b1;
      return res;
    end
    x = int'(it.row) - (w - 1) / 2;
    y = int'(it.column) - (w - 1) / 2;
    r2 = x * x + y * y;
    acc = ONE_Q30;
    base = GAUSS_BASE[nu];
    while (r2 != 0) begin
      if (r2[0]) acc = qprod(acc, base);
      base = qprod(base, base);
      r2 = r2 >> 1;
    end
    g = qprod(PI_EIGHTH, acc);
    sum = longint'(x) * COS_DIR[mu] + longint'(y) * SIN_DIR[mu];
    ph = (64'(sum) * ROOT_SCALE[nu]) & ((64'd1 << 60) - 1);
    quad = ph[59:58];
    u = (ph & ((64'd1 << 58) - 1)) >> 28;
    a = qprod(u, HALF_PI);
    z = qprod(a, a);
    sn = qprod(a, taylor_core(z, 1'b1));
    cs = taylor_core(z, 1'b0);
    case (quad)
      2'd0: begin sv = sn; cv = cs; end
      2'd1: begin sv = cs; cv = -longint'(sn); end
      2'd2: begin sv = -longint'(sn); cv = -longint'(cs); end
      default: begin sv = -longint'(cs); cv = sn; end
    endcase
    res.real_coef = to_q15(g, cv - DC_OFFSET, nu);
    res.imag_coef = to_q15(g, sv, nu);
    return res;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[gabor_kernel_generator_top] ERROR");
      $finish;
    end
  end

  // driver: offer queued items, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        expected_coefs.push_back(kernel_coef(shadow_mu, shadow_nu, item));
        void'(pending_items.pop_front());
        items_sent <= items_sent + 1;
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
          item <= pending_items[0];
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end else if (!item_valid) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
          item <= pending_items[0];
          item_valid <= 1'b1;
        end
      end
    end
  end

  // receiver readiness, with one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (!held && results_seen == 300) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    gabk_result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      results_seen <= results_seen + 1;
      if (expected_coefs.size() == 0) begin
        $error("result with no expectation: %p", result);
        errors = errors + 1;
      end else begin
        exp_r = expected_coefs.pop_front();
        if (result.real_coef !== exp_r.real_coef) begin
          $error("real_coef expected %0d got %0d", exp_r.real_coef, result.real_coef);
          errors = errors + 1;
        end
        if (result.imag_coef !== exp_r.imag_coef) begin
          $error("imag_coef expected %0d got %0d", exp_r.imag_coef, result.imag_coef);
          errors = errors + 1;
        end
        if (result.mask_size !== exp_r.mask_size) begin
          $error("mask_size expected %0d got %0d", exp_r.mask_size, result.mask_size);
          errors = errors + 1;
        end
        if (result.outside_mask !== exp_r.outside_mask) begin
          $error("outside_mask expected %0d got %0d", exp_r.outside_mask,
                 result.outside_mask);
          errors = errors + 1;
        end
      end
    end
  end

  // apb register write, shadow updated at the access edge
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_ORIENTATION) shadow_mu = data[2:0];
    else shadow_nu = data[2:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_item(input int r, input int c);
    gabk_item_t it;
    it.row = 6'(r);
    it.column = 6'(c);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || item_valid || expected_coefs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    int scales [PHASES] = '{0, 4, 7, 1, 2, 3, 5, 6, 4, 0};
    int w;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    shadow_mu = '0; shadow_nu = '0;
    calm = 1'b0; held = 1'b0; hold_left = 0;
    errors = 0; results_seen = 0; items_sent = 0; cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed corners at reset settings: centre, mask edges, field extremes
    add_item(0, 0);   add_item(63, 63); add_item(5, 5);   add_item(10, 10);
    add_item(11, 0);  add_item(0, 11);  add_item(10, 0);  add_item(0, 10);
    add_item(63, 0);  add_item(0, 63);  add_item(5, 0);   add_item(0, 5);
    add_item(21, 42); add_item(42, 21); add_item(5, 10);  add_item(10, 5);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      // upper bits of the write data are junk the block must drop
      reg_write(ADDR_ORIENTATION, {$urandom()} & ~32'h7 | (p == 9 ? 7 : p % 8));
      reg_write(ADDR_SCALE, ({$urandom()} & ~32'h7) | 32'(scales[p]));
      w = WIDTHS[(scales[p] > MAX_SCALE) ? MAX_SCALE : scales[p]];
      if (p == 1) begin
        add_item(38, 38); add_item(39, 19); add_item(19, 39); add_item(19, 19);
      end
      calm = (p == 4);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(99) < 85) add_item($urandom_range(w - 1), $urandom_range(w - 1));
        else add_item($urandom_range(63), $urandom_range(63));
      end
      wait_idle();
    end

    $display("covered %0d kernel positions over %0d orientation/scale settings",
             items_sent, PHASES + 1);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0 && expected_coefs.size() == 0) begin
      $display("[gabor_kernel_generator_top] OK");
    end else begin
      $display("[gabor_kernel_generator_top] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
